// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
package bse_pkg;

   localparam int unsigned HDR_LEN   = 54;
   localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);
   localparam logic [31:0] DIB_LEN    = 32'd40;
   localparam logic [7:0]  BPP        = 8'd24;
   localparam logic [7:0]  PLANES     = 8'd1;
   localparam logic [31:0] PPM        = 32'd2835;
   localparam logic [7:0]  CHAR_B     = 8'h42;
   localparam logic [7:0]  CHAR_M     = 8'h4D;
   // Largest padded image size that still fits a 32-bit file size.
   localparam logic [31:0] FILE_LIMIT = 32'hFFFF_FFC9;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       frame_end;
      logic       limit_error;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_HEADER,
      CMD_ERROR,
      CMD_PIXEL
   } cmd_kind_type;

   // One unit of work for the byte emitter.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [1:0]   pad;
      logic         frame_end;
      logic [31:0]  img_size;
   } cmd_type;

endpackage

// ===== rtl/bse_front.sv =====
module bse_front #(
   parameter int DIM_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bse_pkg::req_type     req_data,
   input  logic [DIM_BITS-1:0]  width,
   input  logic [DIM_BITS-1:0]  height,
   output logic                 push,
   output bse_pkg::cmd_type     push_cmd,
   input  logic                 q_room
);

   localparam int SW = DIM_BITS + 2;
   localparam int PW = SW + DIM_BITS;
   localparam int CW = (PW > 32) ? PW : 32;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } fstate_type;

   fstate_type          state_ff, state_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic                open_ff, open_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [PW-1:0]       mcand_ff, mcand_in;
   logic [DIM_BITS-1:0] mplier_ff, mplier_in;

   logic [SW-1:0]       w3;
   logic [SW-1:0]       rnd;
   logic [SW-1:0]       stride;
   logic [DIM_BITS-1:0] next_col;
   logic [DIM_BITS-1:0] next_row;
   logic                row_end;
   logic                frm_end;
   logic                accept;
   logic                empty;
   logic                over;
   logic [CW-1:0]       acc_ext;

   assign req_ready = (state_ff == F_IDLE) && q_room;
   assign accept    = req_valid && req_ready;

   always_comb begin
      w3       = SW'({width, 1'b0}) + SW'(width);
      rnd      = w3 + SW'(3);
      stride   = {rnd[SW-1:2], 2'b00};
      next_col = col_ff + DIM_BITS'(1);
      next_row = row_ff + DIM_BITS'(1);
      row_end  = next_col >= width;
      frm_end  = row_end && (next_row >= height);
      empty    = (width == '0) || (height == '0);
      acc_ext  = CW'(acc_ff);
      over     = acc_ext > CW'(bse_pkg::FILE_LIMIT);
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      open_in   = open_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      push      = 1'b0;
      push_cmd  = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_data.action == bse_pkg::ACT_START) begin
                  col_in    = '0;
                  row_in    = '0;
                  open_in   = 1'b0;
                  acc_in    = '0;
                  mcand_in  = PW'(stride);
                  mplier_in = height;
                  state_in  = F_MUL;
               end else if (open_ff) begin
                  push             = 1'b1;
                  push_cmd.kind    = bse_pkg::CMD_PIXEL;
                  push_cmd.red     = req_data.red;
                  push_cmd.green   = req_data.green;
                  push_cmd.blue    = req_data.blue;
                  // Row padding is (4 - 3*width mod 4) mod 4, which equals width mod 4.
                  push_cmd.pad       = row_end ? width[1:0] : 2'b00;
                  push_cmd.frame_end = frm_end;
                  if (row_end) begin
                     col_in  = '0;
                     row_in  = frm_end ? '0 : next_row;
                     open_in = !frm_end;
                  end else begin
                     col_in = next_col;
                  end
               end
            end
         end
         F_MUL: begin
            // Shift-add multiply of stride by height, one height bit a cycle.
            if (mplier_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         F_PUSH: begin
            if (q_room) begin
               push               = 1'b1;
               push_cmd.kind      = over ? bse_pkg::CMD_ERROR : bse_pkg::CMD_HEADER;
               push_cmd.img_size  = acc_ext[31:0];
               push_cmd.frame_end = empty && !over;
               open_in            = !over && !empty;
               state_in           = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         open_ff  <= open_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

// ===== rtl/bse_queue.sv =====
module bse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bse_pkg::cmd_type push_cmd,
   output logic             room,
   input  logic             pop,
   output logic             head_valid,
   output bse_pkg::cmd_type head
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   bse_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign room       = count_ff != (PTR_W + 1)'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bse_back.sv =====
module bse_back #(
   parameter int DIM_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  bse_pkg::cmd_type    head,
   output logic                pop,
   input  logic [DIM_BITS-1:0] width,
   input  logic [DIM_BITS-1:0] height,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bse_pkg::rsp_type    rsp_data
);

   localparam int IW = bse_pkg::HDR_IDX_W;

   logic [IW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bse_pkg::rsp_type rsp_ff, rsp_in;
   logic [IW-1:0]    last_idx;
   logic             fire;
   logic             is_last;
   logic [7:0]       cur_byte;
   logic [31:0]      total_size;

   // Header layout: 32-bit fields start at offsets 2 mod 4, so the byte
   // within a field is the low offset bits with bit 1 flipped.
   function automatic logic [7:0] hdr_byte(input logic [IW-1:0] idx,
                                           input logic [31:0] fsize,
                                           input logic [31:0] wd,
                                           input logic [31:0] ht,
                                           input logic [31:0] img);
      logic [1:0] sel;
      logic [7:0] b;
      sel = idx[1:0] ^ 2'b10;
      b   = '0;
      unique case (idx) inside
         IW'(0):              b = bse_pkg::CHAR_B;
         IW'(1):              b = bse_pkg::CHAR_M;
         [IW'(2):IW'(5)]:     b = fsize[{sel, 3'b000} +: 8];
         [IW'(10):IW'(13)]:   b = bse_pkg::HDR_LEN[{sel, 3'b000} +: 8];
         [IW'(14):IW'(17)]:   b = bse_pkg::DIB_LEN[{sel, 3'b000} +: 8];
         [IW'(18):IW'(21)]:   b = wd[{sel, 3'b000} +: 8];
         [IW'(22):IW'(25)]:   b = ht[{sel, 3'b000} +: 8];
         IW'(26):             b = bse_pkg::PLANES;
         IW'(28):             b = bse_pkg::BPP;
         [IW'(34):IW'(37)]:   b = img[{sel, 3'b000} +: 8];
         [IW'(38):IW'(45)]:   b = bse_pkg::PPM[{sel, 3'b000} +: 8];
         default:             b = '0;
      endcase
      return b;
   endfunction

   assign total_size = head.img_size + 32'(bse_pkg::HDR_LEN);
   assign fire       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last    = idx_ff == last_idx;
   assign pop        = fire && is_last;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      unique case (head.kind)
         bse_pkg::CMD_HEADER: begin
            last_idx = IW'(bse_pkg::HDR_LEN - 1);
            cur_byte = hdr_byte(idx_ff, total_size, 32'(width), 32'(height),
                                head.img_size);
         end
         bse_pkg::CMD_PIXEL: begin
            last_idx = IW'(2) + IW'(head.pad);
            case (idx_ff)
               IW'(0):  cur_byte = head.blue;
               IW'(1):  cur_byte = head.green;
               IW'(2):  cur_byte = head.red;
               default: cur_byte = '0;
            endcase
         end
         default: begin
            last_idx = '0;
            cur_byte = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in.out_byte    = cur_byte;
      rsp_in.last        = is_last;
      rsp_in.frame_end   = is_last && head.frame_end;
      rsp_in.limit_error = head.kind == bse_pkg::CMD_ERROR;
      if (fire) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? '0 : idx_ff + IW'(1);
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         idx_in       = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/bmp24_stream_encoder.sv =====
// Streams a 24-bit uncompressed BMP file one byte per cycle while rsp_ready
// does not stall it. A start request first runs a shift-add multiply of the
// padded row stride by the height in the front end, and then emits the 54
// header bytes at one per cycle, as back-pressure allows, or a single error
// byte when the image would not fit a 32-bit file size. Each pixel request
// produces blue, green and red, plus zero to three padding bytes at row end;
// a two-entry command queue lets new requests be taken while earlier bytes
// are still going out. Pixels that arrive with no frame open are accepted and
// dropped. The user must write width and height through the csr port only
// while no request is in flight; the block itself does not enforce this.
module bmp24_stream_encoder #(
   parameter int DIM_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bse_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bse_pkg::rsp_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_wdata
);

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;

   logic             push;
   bse_pkg::cmd_type push_cmd;
   logic             q_room;
   logic             pop;
   logic             head_valid;
   bse_pkg::cmd_type head;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bse_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            bse_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   bse_front #(.DIM_BITS(DIM_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .width     (width_ff),
      .height    (height_ff),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_room    (q_room)
   );

   bse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .room       (q_room),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   bse_back #(.DIM_BITS(DIM_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .width      (width_ff),
      .height     (height_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/bse_checker.sv =====
`include "assert_macros.svh"

module bse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bse_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bse_pkg::rsp_type rsp_data
);

   // A stalled response keeps its valid and its payload.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   // The overflow response is a lone zero byte that closes its request.
   `ASSERT_SAME(a_err_shape, rsp_valid && rsp_data.limit_error, rsp_data.last && !rsp_data.frame_end && rsp_data.out_byte == 8'h00, "malformed limit error response")

   // The end of the file is always the end of the request that caused it.
   `ASSERT_SAME(a_end_last, rsp_valid && rsp_data.frame_end, rsp_data.last, "frame end without last")

   // Right after reset the block is ready and presents nothing.
   `ASSERT_SAME(a_quiet_reset, $fell(reset), req_ready && !rsp_valid, "not idle after reset")

   // A waiting request keeps its valid and its payload.
   `ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data), "request changed while waiting")

endmodule

bind bmp24_stream_encoder bse_checker u_bse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
